// ----- hw/rtl/bmpp_pkg.sv -----
// Shared types, constants and register codes of the basket max path payoff block.
`default_nettype none

package bmpp_pkg;

	// Sizing
	localparam int NUM_ASSETS_DEF = 4;
	localparam int ACC_W          = 40;
	localparam int X_W            = ACC_W + 1;
	localparam int MAG_W          = 34;
	localparam int MA_W           = 34;
	localparam int MB_W           = 32;
	localparam int MP_W           = MA_W + MB_W;
	localparam int CFG_IDX_W      = 3;
	localparam int SHIFT_W        = 80;

	// Configuration register codes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DISCOUNT   = 3'd0,
		REG_ANTITHETIC = 3'd1,
		REG_SPOT0      = 3'd2,
		REG_SPOT1      = 3'd3,
		REG_SPOT2      = 3'd4,
		REG_SPOT3      = 3'd5
	} cfg_reg_t;

	localparam logic [31:0] DISCOUNT_RST = 32'h4000_0000;
	localparam logic [31:0] MAX32        = 32'hFFFF_FFFF;

	// Accumulator limits, signed Q12.28
	localparam logic [ACC_W-1:0] ACC_MAX = 40'h7F_FFFF_FFFF;
	localparam logic [ACC_W-1:0] ACC_MIN = 40'h80_0000_0000;

	// Exponent clamp: 32.0 in Q28
	localparam logic [MAG_W-1:0] X_LIM = 34'h2_0000_0000;

	// log2(e) and ln(2), Q30
	localparam logic [31:0] L2E_Q30 = 32'd1549082005;
	localparam logic [31:0] LN2_Q30 = 32'd744261118;

	// Taylor coefficients 1/n! in Q30, lowest order first; top term separate
	localparam logic [31:0] TAYLOR_Q30 [8] = '{
		32'd1073741824, 32'd1073741824, 32'd536870912, 32'd178956971,
		32'd44739243,   32'd8947849,    32'd1491308,   32'd213044
	};
	localparam logic [31:0] TAYLOR_TOP = 32'd26631;

	// Price scaling: right shift of (spot * 2^f) * 2^16 by 46 - k
	localparam logic [6:0] SHIFT_BASE = 7'd46;

	// Input and result transactions
	typedef struct packed {
		logic [1:0]         asset_index;
		logic signed [31:0] drift_step;
		logic signed [31:0] diffusion_step;
		logic               last_step;
		logic               last_asset;
	} bmpp_in_t;

	typedef struct packed {
		logic [31:0] path_value;
		logic        saturated;
	} bmpp_out_t;

	// Shared multiplier request and response
	typedef struct packed {
		logic            start;
		logic [MA_W-1:0] a;
		logic [MB_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic            busy;
		logic            done;
		logic [MP_W-1:0] prod;
	} mul_rsp_t;

	// Accumulator controls
	typedef struct packed {
		logic add;
		logic clr_sums;
		logic clr_path;
	} acc_ctrl_t;

	// Result load toward the output register
	typedef struct packed {
		logic      load;
		bmpp_out_t data;
	} res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bmpp_mul.sv -----
// Bit-serial shift-add multiplier shared by every product of the block.
`default_nettype none

module bmpp_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  bmpp_pkg::mul_req_t req,
	output bmpp_pkg::mul_rsp_t rsp
);
	import bmpp_pkg::*;

	localparam int CNT_W = $clog2(MB_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MP_W-1:0]  a_sh_q;
	logic [MP_W-1:0]  acc_q;
	logic [MB_W-1:0]  b_q;

	// Iteration control: one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MB_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: add the shifted multiplicand where the low bit of b is set
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_sh_q <= MP_W'(req.a);
			b_q    <= req.b;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_sh_q;
			end
			a_sh_q <= a_sh_q << 1;
			b_q    <= b_q >> 1;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

	// Checks
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("multiplier done held longer than one cycle");

	a_cnt_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> busy_q)
		else $error("multiplier counter running while idle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> (busy_q && !done_q))
		else $error("multiplier did not begin after start");

endmodule

`default_nettype wire

// ----- hw/rtl/bmpp_accum.sv -----
// Saturating drift and diffusion log-price accumulators.
`default_nettype none

module bmpp_accum (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bmpp_pkg::acc_ctrl_t   ctrl,
	input  logic signed [31:0]    drift_step,
	input  logic signed [31:0]    diffusion_step,
	output logic signed [40:0]    x_plus,
	output logic signed [40:0]    x_minus,
	output logic                  ovf
);
	import bmpp_pkg::*;

	logic [ACC_W-1:0] drift_q;
	logic [ACC_W-1:0] diff_q;
	logic             ovf_q;
	logic [X_W-1:0]   drift_raw;
	logic [X_W-1:0]   diff_raw;
	logic [ACC_W-1:0] drift_d;
	logic [ACC_W-1:0] diff_d;
	logic             drift_ovf;
	logic             diff_ovf;

	// Sign-extended sums with clamp to the 40-bit limits
	always_comb begin
		drift_raw = {drift_q[ACC_W-1], drift_q}
			+ {{(X_W-32){drift_step[31]}}, drift_step};
		diff_raw  = {diff_q[ACC_W-1], diff_q}
			+ {{(X_W-32){diffusion_step[31]}}, diffusion_step};
		drift_ovf = drift_raw[X_W-1] != drift_raw[ACC_W-1];
		diff_ovf  = diff_raw[X_W-1] != diff_raw[ACC_W-1];
		drift_d   = drift_ovf ? (drift_raw[X_W-1] ? ACC_MIN : ACC_MAX)
			: drift_raw[ACC_W-1:0];
		diff_d    = diff_ovf ? (diff_raw[X_W-1] ? ACC_MIN : ACC_MAX)
			: diff_raw[ACC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drift_q <= '0;
			diff_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (ctrl.clr_path) begin
			drift_q <= '0;
			diff_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (ctrl.clr_sums) begin
			drift_q <= '0;
			diff_q  <= '0;
		end else if (ctrl.add) begin
			drift_q <= drift_d;
			diff_q  <= diff_d;
			ovf_q   <= ovf_q | drift_ovf | diff_ovf;
		end
	end

	// Exponents of the path and its mirror
	assign x_plus  = {drift_q[ACC_W-1], drift_q} + {diff_q[ACC_W-1], diff_q};
	assign x_minus = {drift_q[ACC_W-1], drift_q} - {diff_q[ACC_W-1], diff_q};
	assign ovf     = ovf_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bmpp_seq.sv -----
// Sequencer: fixed-point exponential, asset price, running maxima and payoff.
`default_nettype none

module bmpp_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_last_step,
	input  logic                 in_last_asset,
	input  logic [31:0]          spot_sel,
	input  logic signed [40:0]   x_plus,
	input  logic signed [40:0]   x_minus,
	input  logic                 acc_ovf,
	input  logic                 antithetic,
	input  logic [31:0]          discount,
	input  logic                 slot_free,
	output bmpp_pkg::acc_ctrl_t  actl,
	output bmpp_pkg::mul_req_t   mreq,
	input  bmpp_pkg::mul_rsp_t   mul_rsp,
	output bmpp_pkg::res_t       res
);
	import bmpp_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_PREP  = 10'b00_0000_0010,
		S_TMUL  = 10'b00_0000_0100,
		S_UMUL  = 10'b00_0000_1000,
		S_HMUL  = 10'b00_0001_0000,
		S_PMUL  = 10'b00_0010_0000,
		S_SHIFT = 10'b00_0100_0000,
		S_BASE  = 10'b00_1000_0000,
		S_DMUL  = 10'b01_0000_0000,
		S_OUT   = 10'b10_0000_0000
	} state_t;

	state_t             state_q;
	state_t             state_d;
	logic               minus_q;
	logic [31:0]        best_plus_q;
	logic [31:0]        best_minus_q;
	logic               sat_q;
	logic [2:0]         hcnt_q;
	logic [31:0]        spot_q;
	logic               last_asset_q;
	logic               neg_q;
	logic [6:0]         k_q;
	logic [29:0]        u_q;

	logic [X_W-1:0]     x_sel;
	logic               x_neg;
	logic [X_W-1:0]     x_abs;
	logic [MAG_W-1:0]   mag;
	logic [33:0]        t_val;
	logic [5:0]         t_int;
	logic [27:0]        t_frac;
	logic [6:0]         k_val;
	logic [27:0]        f_val;
	logic [29:0]        u_val;
	logic [31:0]        p_next;
	logic [6:0]         amt;
	logic [SHIFT_W-1:0] sh_out;
	logic               price_sat;
	logic [31:0]        price_val;
	logic [32:0]        pair_sum;
	logic [31:0]        base;
	logic [33:0]        pay;
	logic               pay_sat;

	// Clamp and magnitude of the exponent for the current pass
	always_comb begin
		x_sel = minus_q ? x_minus : x_plus;
		x_neg = x_sel[X_W-1];
		x_abs = x_neg ? (X_W'(0) - x_sel) : x_sel;
		mag   = (x_abs > X_W'(X_LIM)) ? X_LIM : x_abs[MAG_W-1:0];
	end

	// Split t = |x| * log2(e) into integer k (floor of the signed value) and fraction; also u and the Horner sum
	always_comb begin
		t_val  = mul_rsp.prod[63:30];
		t_int  = t_val[33:28];
		t_frac = t_val[27:0];
		if (!neg_q) begin
			k_val = {1'b0, t_int};
			f_val = t_frac;
		end else if (t_frac == '0) begin
			k_val = 7'd0 - {1'b0, t_int};
			f_val = '0;
		end else begin
			k_val = 7'd0 - ({1'b0, t_int} + 7'd1);
			f_val = 28'd0 - t_frac;
		end
		u_val  = mul_rsp.prod[57:28];
		p_next = TAYLOR_Q30[hcnt_q] + mul_rsp.prod[61:30];
	end

	// Price: (spot * 2^f) scaled by 2^k, saturated to 32 bits
	always_comb begin
		amt       = SHIFT_BASE - k_q;
		sh_out    = {mul_rsp.prod[63:0], 16'h0000} >> amt;
		price_sat = |sh_out[SHIFT_W-1:32];
		price_val = price_sat ? MAX32 : sh_out[31:0];
	end

	// Payoff base and discounted value
	always_comb begin
		pair_sum = {1'b0, best_plus_q} + {1'b0, best_minus_q};
		base     = antithetic ? pair_sum[32:1] : best_plus_q;
		pay      = mul_rsp.prod[63:30];
		pay_sat  = |pay[33:32];
	end

	// Next state and unit commands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		actl     = '0;
		mreq     = '0;
		res      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				actl.add = in_valid;
				if (in_valid && in_last_step) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				mreq.start = 1'b1;
				mreq.a     = mag;
				mreq.b     = L2E_Q30;
				state_d    = S_TMUL;
			end
			S_TMUL: begin
				if (mul_rsp.done) begin
					mreq.start = 1'b1;
					mreq.a     = MA_W'(f_val);
					mreq.b     = LN2_Q30;
					state_d    = S_UMUL;
				end
			end
			S_UMUL: begin
				if (mul_rsp.done) begin
					mreq.start = 1'b1;
					mreq.a     = MA_W'(TAYLOR_TOP);
					mreq.b     = MB_W'(u_val);
					state_d    = S_HMUL;
				end
			end
			S_HMUL: begin
				if (mul_rsp.done) begin
					mreq.start = 1'b1;
					if (hcnt_q == '0) begin
						mreq.a  = MA_W'(spot_q);
						mreq.b  = p_next;
						state_d = S_PMUL;
					end else begin
						mreq.a = MA_W'(p_next);
						mreq.b = MB_W'(u_q);
					end
				end
			end
			S_PMUL: begin
				if (mul_rsp.done) begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (!minus_q && antithetic) begin
					state_d = S_PREP;
				end else begin
					actl.clr_sums = 1'b1;
					state_d       = last_asset_q ? S_BASE : S_IDLE;
				end
			end
			S_BASE: begin
				mreq.start = 1'b1;
				mreq.a     = MA_W'(discount);
				mreq.b     = base;
				state_d    = S_DMUL;
			end
			S_DMUL: begin
				if (mul_rsp.done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (slot_free) begin
					res.load            = 1'b1;
					res.data.path_value = pay_sat ? MAX32 : pay[31:0];
					res.data.saturated  = sat_q | acc_ovf | pay_sat;
					actl.clr_path       = 1'b1;
					state_d             = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state, maxima and sticky saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			minus_q      <= 1'b0;
			best_plus_q  <= '0;
			best_minus_q <= '0;
			sat_q        <= 1'b0;
			hcnt_q       <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						minus_q <= 1'b0;
					end
				end
				S_UMUL: begin
					if (mul_rsp.done) begin
						hcnt_q <= '1;
					end
				end
				S_HMUL: begin
					if (mul_rsp.done) begin
						hcnt_q <= hcnt_q - 1'b1;
					end
				end
				S_SHIFT: begin
					sat_q <= sat_q | price_sat;
					if (minus_q) begin
						if (price_val > best_minus_q) begin
							best_minus_q <= price_val;
						end
					end else if (price_val > best_plus_q) begin
						best_plus_q <= price_val;
					end
					if (!minus_q && antithetic) begin
						minus_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (slot_free) begin
						best_plus_q  <= '0;
						best_minus_q <= '0;
						sat_q        <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Per-asset operands
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_last_step) begin
					spot_q       <= spot_sel;
					last_asset_q <= in_last_asset;
				end
			end
			S_PREP: begin
				neg_q <= x_neg;
			end
			S_TMUL: begin
				if (mul_rsp.done) begin
					k_q <= k_val;
				end
			end
			S_UMUL: begin
				if (mul_rsp.done) begin
					u_q <= u_val;
				end
			end
			default: begin
			end
		endcase
	end

	// Checks
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.start |-> !mul_rsp.busy)
		else $error("multiplier started while busy");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |-> slot_free)
		else $error("result loaded over a pending transaction");

	a_busy_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last_step) |=> !in_ready)
		else $error("input taken during price evaluation");

	a_clear_path: assert property (@(posedge clk) disable iff (!arst_n)
		actl.clr_path |=> (best_plus_q == '0 && best_minus_q == '0 && !sat_q))
		else $error("path state not cleared after result");

endmodule

`default_nettype wire

// ----- hw/rtl/basket_max_path_payoff.sv -----
// Top level of the basket max path payoff block: configuration, accumulators, sequencer, output.
`default_nettype none

// Each transaction on the input is one time step of one asset's log-price path.
// A step that does not end its asset is summed in the cycle it is taken, so such
// steps stream at one per cycle. The step that ends an asset holds the input off
// until its price is done (twice over in antithetic mode, for the path and its
// mirror): the price comes from eleven products (log2(e) scaling, ln(2) scaling,
// eight Horner terms, spot) on one bit-serial 34x32 multiplier, plus a state to
// set up the exponent and one to scale and compare the price. A step that also
// ends the path adds the discount product and the result hand-off, plus any wait
// for the output register to be taken. Configuration writes are taken every cycle
// and belong in idle time only; spot registers beyond NUM_ASSETS are not stored
// and those assets price at zero.
module basket_max_path_payoff #(
	parameter int NUM_ASSETS = bmpp_pkg::NUM_ASSETS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  bmpp_pkg::bmpp_in_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output bmpp_pkg::bmpp_out_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bmpp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                        cfg_data
);
	import bmpp_pkg::*;

	logic [31:0]        discount_q;
	logic               anti_q;
	logic [31:0]        spot_q [NUM_ASSETS];
	logic [31:0]        spot_sel;
	logic               out_valid_q;
	bmpp_out_t          out_data_q;
	logic               slot_free;
	logic signed [40:0] x_plus;
	logic signed [40:0] x_minus;
	logic               acc_ovf;
	acc_ctrl_t          actl;
	mul_req_t           mreq;
	mul_rsp_t           mrsp;
	res_t               res;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discount_q <= DISCOUNT_RST;
			anti_q     <= 1'b0;
			for (int i = 0; i < NUM_ASSETS; i++) begin
				spot_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == REG_DISCOUNT) begin
				discount_q <= cfg_data;
			end
			if (cfg_index == REG_ANTITHETIC) begin
				anti_q <= cfg_data[0];
			end
			for (int i = 0; i < NUM_ASSETS; i++) begin
				if (cfg_index == CFG_IDX_W'(int'(REG_SPOT0) + i)) begin
					spot_q[i] <= cfg_data;
				end
			end
		end
	end

	// Spot of the asset in the current transaction; unstored assets read zero
	always_comb begin
		spot_sel = '0;
		for (int i = 0; i < NUM_ASSETS; i++) begin
			if (in_data.asset_index == 2'(i)) begin
				spot_sel = spot_q[i];
			end
		end
	end

	bmpp_accum u_accum (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (actl),
		.drift_step     (in_data.drift_step),
		.diffusion_step (in_data.diffusion_step),
		.x_plus         (x_plus),
		.x_minus        (x_minus),
		.ovf            (acc_ovf)
	);

	bmpp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	bmpp_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_last_step  (in_data.last_step),
		.in_last_asset (in_data.last_asset),
		.spot_sel      (spot_sel),
		.x_plus        (x_plus),
		.x_minus       (x_minus),
		.acc_ovf       (acc_ovf),
		.antithetic    (anti_q),
		.discount      (discount_q),
		.slot_free     (slot_free),
		.actl          (actl),
		.mreq          (mreq),
		.mul_rsp       (mrsp),
		.res           (res)
	);

	// Output register
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			out_data_q <= res.data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
